// ===== hdl/rtdt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtdt_pkg
// Shared types, widths, constants and stage map of the RTD code to
// temperature converter.
// ----------------------------------------------------------------------------
package rtdt_pkg;

  // Default number of fractional bits of both results
  localparam int FRAC_BITS_DEFAULT = 6;

  // Field and register widths
  localparam int WORD_W     = 16;
  localparam int CODE_W     = 15;
  localparam int REF_W      = 13;
  localparam int NOM_W      = 10;
  localparam int RES_W      = 19;
  localparam int TEMP_W     = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_OHMS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOMINAL_OHMS   = 2'd1;

  // Register reset values
  localparam logic [REF_W-1:0] REFERENCE_OHMS_RST = 13'd430;
  localparam logic [NOM_W-1:0] NOMINAL_OHMS_RST   = 10'd100;

  // Datapath widths
  localparam int N_W        = CODE_W + REF_W;   // code * reference ohms
  localparam int B4_W       = 28;
  localparam int P_W        = N_W + B4_W;       // 4|B| scaled product
  localparam int DIV_FRAC   = 17;               // 2^32 / 2^15
  localparam int DIV_STEPS  = 8;                // quotient bits per stage
  localparam int DIV_STAGES = 10;
  localparam int DIV_W      = DIV_STEPS * DIV_STAGES;
  localparam int SQ_IN_W    = 64;
  localparam int SQ_ROOT_W  = 32;
  localparam int SQ_REM_W   = 34;
  localparam int SQ_STEPS   = 4;                // root bits per stage
  localparam int SQ_STAGES  = 8;
  localparam int MAG_W      = 32;
  localparam int PROD_W     = 49;
  localparam int Q_W        = 17;

  // Scaled Callendar-Van Dusen constants
  localparam logic [B4_W-1:0]      B4_CONST   = 28'd231000000;
  localparam logic [30:0]          G_CONST    = 31'd1758480889;
  localparam logic [MAG_W-1:0]     A_SHIFTED  = 32'd2561343488;
  localparam logic [22:0]          HALF_DEN   = 23'd7569408;    // 231 * 2^15
  localparam logic [23:0]          SAT_LIM    = 24'd15138816;   // 231 * 2^16
  localparam logic [24:0]          RECIP_231  = 25'd18592933;   // ceil(2^32/231)
  localparam int                   RECIP_SH   = 32;
  localparam logic [RES_W-1:0]     R_MAX      = 19'h7FFFF;
  localparam logic signed [TEMP_W-1:0] T_HIGH = 17'sd65535;
  localparam logic signed [TEMP_W-1:0] T_LOW  = -17'sd16384;
  localparam logic [Q_W-1:0]       Q_POS_MAX  = 17'd65535;
  localparam logic [Q_W-1:0]       Q_NEG_MAX  = 17'd16384;

  // Stage map
  localparam int ST_MUL1    = 0;
  localparam int ST_MUL2    = 1;
  localparam int ST_DIV0    = 2;
  localparam int ST_CMP     = ST_DIV0 + DIV_STAGES;
  localparam int ST_SQ0     = ST_CMP + 1;
  localparam int ST_SCALE   = ST_SQ0 + SQ_STAGES;
  localparam int ST_RECIP   = ST_SCALE + 1;
  localparam int ST_OUT     = ST_RECIP + 1;
  localparam int NUM_STAGES = ST_OUT + 1;

  // Per-stage load enables and valid bits
  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
    logic [NUM_STAGES-1:0] valid;
  } pipe_ctl_t;

endpackage

// ===== hdl/rtdt_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtdt_if
// Valid/ready channels of the RTD converter: data word in, result word out
// and the register write port.
// ----------------------------------------------------------------------------
interface rtdt_in_if;
  logic                           valid;
  logic                           ready;
  logic [rtdt_pkg::WORD_W-1:0]    rtd_word;
  modport source (output valid, rtd_word, input ready);
  modport sink   (input valid, rtd_word, output ready);
endinterface

interface rtdt_out_if;
  logic                                valid;
  logic                                ready;
  logic [rtdt_pkg::RES_W-1:0]          resistance;
  logic signed [rtdt_pkg::TEMP_W-1:0]  temperature;
  logic                                out_of_range;
  modport source (output valid, resistance, temperature, out_of_range, input ready);
  modport sink   (input valid, resistance, temperature, out_of_range, output ready);
endinterface

interface rtdt_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [rtdt_pkg::CFG_IDX_W-1:0]    index;
  logic [rtdt_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/rtdt_pipe_ctl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtdt_pipe_ctl
// Valid bits and load enables of the converter pipeline. A stage loads when
// the output is ready or when it or any later stage has a hole, so bubbles close
// up and a stall at the output holds every word in place once every stage is full.
// ----------------------------------------------------------------------------
module rtdt_pipe_ctl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                out_ready,
  output rtdt_pkg::pipe_ctl_t ctl
);

  localparam int NS = rtdt_pkg::NUM_STAGES;

  logic [NS-1:0] valid_r;
  logic [NS-1:0] valid_nxt;
  logic [NS-1:0] load;

  // Find a hole at or after each stage
  always_comb begin
    for (int k = 0; k < NS; k++) begin
      load[k] = out_ready || !(&(valid_r | ((NS'(1) << k) - NS'(1))));
    end
  end

  // Advance valid bits with the data
  always_comb begin
    for (int k = 0; k < NS; k++) begin
      if (load[k]) begin
        valid_nxt[k] = (k == 0) ? in_valid : valid_r[(k == 0) ? 0 : k-1];
      end else begin
        valid_nxt[k] = valid_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign ctl.load  = load;
  assign ctl.valid = valid_r;

endmodule

// ===== hdl/rtd_code_to_temperature_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtd_code_to_temperature_core
// RTD data word to resistance and temperature (inverse Callendar-Van Dusen).
//
// in_ch takes one 16-bit converter word per handshake; bit 0 (fault) is
// dropped. out_ch gives resistance and temperature in units of 2^-FRAC_BITS
// and an out_of_range flag. cfg_ch writes reference_ohms (index 0) and
// nominal_ohms (index 1) and is always ready; the user must write it only
// while no word is in flight (not enforced). Unknown indexes are ignored.
// A word passes through 24 register stages from input handshake to output
// valid: two multiply stages, ten long-division stages of 8 quotient bits,
// one compare, eight square-root stages of 4 root bits, and three scaling
// stages. A new word is taken every cycle while no output stall has filled
// every stage; the rate is then one word per clock.
// When out_ch stalls, words hold in place and bubbles ahead of the stall
// close up, so in_ch keeps accepting until every stage is full.
// Reset (synchronous, rst_n low) empties the pipeline and loads the
// registers with 430 ohms reference and 100 ohms nominal.
// ----------------------------------------------------------------------------
module rtd_code_to_temperature_core #(
  parameter int FRAC_BITS = rtdt_pkg::FRAC_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst_n,
  rtdt_in_if.sink           in_ch,
  rtdt_out_if.source        out_ch,
  rtdt_cfg_if.sink          cfg_ch
);

  localparam int RS_W     = rtdt_pkg::N_W + FRAC_BITS + 1;
  localparam int RQ_W     = RS_W - 15;
  localparam int RX_W     = RQ_W + rtdt_pkg::RES_W;
  localparam int YF_W     = rtdt_pkg::MAG_W + 5 + FRAC_BITS + 1;
  localparam int Y_W      = YF_W - 16;
  localparam int DIV_W    = rtdt_pkg::DIV_W;
  localparam int NOM_W    = rtdt_pkg::NOM_W;
  localparam int SQ_IN_W  = rtdt_pkg::SQ_IN_W;
  localparam int SQ_REM_W = rtdt_pkg::SQ_REM_W;
  localparam int SQ_RT_W  = rtdt_pkg::SQ_ROOT_W;

  rtdt_pkg::pipe_ctl_t ctl;

  // Configuration registers
  logic [rtdt_pkg::REF_W-1:0] ref_ohms_r;
  logic [NOM_W-1:0]           nom_ohms_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_ohms_r <= rtdt_pkg::REFERENCE_OHMS_RST;
      nom_ohms_r <= rtdt_pkg::NOMINAL_OHMS_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        rtdt_pkg::REG_REFERENCE_OHMS: ref_ohms_r <= cfg_ch.data;
        rtdt_pkg::REG_NOMINAL_OHMS:   nom_ohms_r <= cfg_ch.data[NOM_W-1:0];
        default: ;
      endcase
    end
  end

  rtdt_pipe_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .ctl       (ctl)
  );

  assign in_ch.ready = ctl.load[rtdt_pkg::ST_MUL1];

  // Stage 0: code times reference ohms
  logic [rtdt_pkg::N_W-1:0] n_r;

  always_ff @(posedge clk) begin
    if (ctl.load[rtdt_pkg::ST_MUL1]) begin
      n_r <= in_ch.rtd_word[rtdt_pkg::WORD_W-1:1] * ref_ohms_r;
    end
  end

  // Stage 1: scaled product for the quotient, rounded resistance
  logic [rtdt_pkg::P_W-1:0]   p_r;
  logic [rtdt_pkg::RES_W-1:0] rq_r [rtdt_pkg::ST_MUL2:rtdt_pkg::ST_OUT];
  logic [RS_W-1:0]            rsum;
  logic [RX_W-1:0]            rext;
  logic [rtdt_pkg::RES_W-1:0] rq_nxt;

  always_comb begin
    rsum   = (RS_W'(n_r) << FRAC_BITS) + RS_W'(1 << 14);
    rext   = RX_W'(rsum[RS_W-1:15]);
    rq_nxt = (rext > RX_W'(rtdt_pkg::R_MAX)) ? rtdt_pkg::R_MAX
                                             : rext[rtdt_pkg::RES_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.load[rtdt_pkg::ST_MUL2]) begin
      p_r                     <= n_r * rtdt_pkg::B4_CONST;
      rq_r[rtdt_pkg::ST_MUL2] <= rq_nxt;
    end
  end

  // Carry resistance down the pipeline
  always_ff @(posedge clk) begin
    for (int k = rtdt_pkg::ST_MUL2 + 1; k <= rtdt_pkg::ST_OUT; k++) begin
      if (ctl.load[k]) begin
        rq_r[k] <= rq_r[k-1];
      end
    end
  end

  // Stages 2..11: restoring division of p * 2^17 by nominal ohms
  logic [NOM_W-1:0] div_rem_r  [rtdt_pkg::DIV_STAGES];
  logic [DIV_W-1:0] div_work_r [rtdt_pkg::DIV_STAGES];

  for (genvar g = 0; g < rtdt_pkg::DIV_STAGES; g++) begin : g_div
    logic [NOM_W-1:0] rem_in;
    logic [DIV_W-1:0] work_in;
    logic [NOM_W-1:0] rem_nxt;
    logic [DIV_W-1:0] work_nxt;

    if (g == 0) begin : g_first
      assign rem_in  = '0;
      assign work_in = DIV_W'({p_r, {rtdt_pkg::DIV_FRAC{1'b0}}});
    end else begin : g_next
      assign rem_in  = div_rem_r[g-1];
      assign work_in = div_work_r[g-1];
    end

    // Shift one dividend bit in, subtract when it fits
    always_comb begin
      logic [NOM_W:0] t;
      rem_nxt  = rem_in;
      work_nxt = work_in;
      for (int s = 0; s < rtdt_pkg::DIV_STEPS; s++) begin
        t        = {rem_nxt, work_nxt[DIV_W-1]};
        work_nxt = {work_nxt[DIV_W-2:0], 1'b0};
        if (t >= {1'b0, nom_ohms_r}) begin
          t           = t - {1'b0, nom_ohms_r};
          work_nxt[0] = 1'b1;
        end
        rem_nxt = t[NOM_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.load[rtdt_pkg::ST_DIV0 + g]) begin
        div_rem_r[g]  <= rem_nxt;
        div_work_r[g] <= work_nxt;
      end
    end
  end

  // Stage 12: root argument, negative check and zero nominal check
  logic [SQ_IN_W-1:0] cmp_rad_r;
  logic               nroot_r [rtdt_pkg::ST_CMP:rtdt_pkg::ST_RECIP];
  logic [DIV_W:0]     cmp_diff;

  always_comb begin
    cmp_diff = {1'b0, DIV_W'(rtdt_pkg::G_CONST) << 32}
             - {1'b0, div_work_r[rtdt_pkg::DIV_STAGES-1]};
  end

  always_ff @(posedge clk) begin
    if (ctl.load[rtdt_pkg::ST_CMP]) begin
      cmp_rad_r                <= cmp_diff[SQ_IN_W-1:0];
      nroot_r[rtdt_pkg::ST_CMP] <= cmp_diff[DIV_W] || (nom_ohms_r == '0);
    end
  end

  // Carry the negative-root flag
  always_ff @(posedge clk) begin
    for (int k = rtdt_pkg::ST_CMP + 1; k <= rtdt_pkg::ST_RECIP; k++) begin
      if (ctl.load[k]) begin
        nroot_r[k] <= nroot_r[k-1];
      end
    end
  end

  // Stages 13..20: digit-by-digit square root, two radicand bits a step
  logic [SQ_IN_W-1:0]  sq_rad_r  [rtdt_pkg::SQ_STAGES];
  logic [SQ_REM_W-1:0] sq_rem_r  [rtdt_pkg::SQ_STAGES];
  logic [SQ_RT_W-1:0]  sq_root_r [rtdt_pkg::SQ_STAGES];

  for (genvar g = 0; g < rtdt_pkg::SQ_STAGES; g++) begin : g_sq
    logic [SQ_IN_W-1:0]  rad_in;
    logic [SQ_REM_W-1:0] rem_in;
    logic [SQ_RT_W-1:0]  root_in;
    logic [SQ_IN_W-1:0]  rad_nxt;
    logic [SQ_REM_W-1:0] rem_nxt;
    logic [SQ_RT_W-1:0]  root_nxt;

    if (g == 0) begin : g_first
      assign rad_in  = cmp_rad_r;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = sq_rad_r[g-1];
      assign rem_in  = sq_rem_r[g-1];
      assign root_in = sq_root_r[g-1];
    end

    // Try the next root bit against the partial remainder
    always_comb begin
      logic [SQ_REM_W+1:0] t;
      logic [SQ_REM_W+1:0] trial;
      rad_nxt  = rad_in;
      rem_nxt  = rem_in;
      root_nxt = root_in;
      for (int s = 0; s < rtdt_pkg::SQ_STEPS; s++) begin
        t       = {rem_nxt, rad_nxt[SQ_IN_W-1 -: 2]};
        trial   = (SQ_REM_W+2)'({root_nxt, 2'b01});
        rad_nxt = {rad_nxt[SQ_IN_W-3:0], 2'b00};
        if (t >= trial) begin
          t        = t - trial;
          root_nxt = {root_nxt[SQ_RT_W-2:0], 1'b1};
        end else begin
          root_nxt = {root_nxt[SQ_RT_W-2:0], 1'b0};
        end
        rem_nxt = t[SQ_REM_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.load[rtdt_pkg::ST_SQ0 + g]) begin
        sq_rad_r[g]  <= rad_nxt;
        sq_rem_r[g]  <= rem_nxt;
        sq_root_r[g] <= root_nxt;
      end
    end
  end

  // Stage 21: |A - s| times 20 * 2^F plus half divisor, over 2^16
  logic [Y_W-1:0]                y_r;
  logic                          sign_r [rtdt_pkg::ST_SCALE:rtdt_pkg::ST_RECIP];
  logic [rtdt_pkg::MAG_W+1:0]    sdiff;
  logic [rtdt_pkg::MAG_W-1:0]    mag;
  logic [rtdt_pkg::MAG_W+4:0]    mag20;
  logic [YF_W-1:0]               yfull;

  always_comb begin
    sdiff = {2'b00, rtdt_pkg::A_SHIFTED}
          - {2'b00, sq_root_r[rtdt_pkg::SQ_STAGES-1]};
    mag   = sdiff[rtdt_pkg::MAG_W+1] ? rtdt_pkg::MAG_W'(-sdiff)
                                     : sdiff[rtdt_pkg::MAG_W-1:0];
    mag20 = {1'b0, mag, 4'b0000} + {3'b000, mag, 2'b00};
    yfull = (YF_W'(mag20) << FRAC_BITS) + YF_W'(rtdt_pkg::HALF_DEN);
  end

  always_ff @(posedge clk) begin
    if (ctl.load[rtdt_pkg::ST_SCALE]) begin
      y_r                       <= yfull[YF_W-1:16];
      sign_r[rtdt_pkg::ST_SCALE] <= sdiff[rtdt_pkg::MAG_W+1];
    end
  end

  // Stage 22: divide by 231 through the reciprocal, flag large magnitudes
  localparam int Q_W_LOC = rtdt_pkg::Q_W;
  logic [Q_W_LOC-1:0] q_r;
  logic                 big_r;
  logic [rtdt_pkg::PROD_W-1:0] prod;

  always_comb begin
    prod = y_r[23:0] * rtdt_pkg::RECIP_231;
  end

  always_ff @(posedge clk) begin
    if (ctl.load[rtdt_pkg::ST_RECIP]) begin
      q_r                        <= prod[rtdt_pkg::PROD_W-1:rtdt_pkg::RECIP_SH];
      big_r                      <= (y_r >= Y_W'(rtdt_pkg::SAT_LIM));
      sign_r[rtdt_pkg::ST_RECIP] <= sign_r[rtdt_pkg::ST_SCALE];
    end
  end

  // Stage 23: apply sign and saturate
  logic signed [rtdt_pkg::TEMP_W-1:0] temp_r;
  logic signed [rtdt_pkg::TEMP_W-1:0] temp_nxt;
  logic                               oor_r;
  logic                               oor_nxt;

  always_comb begin
    temp_nxt = rtdt_pkg::T_HIGH;
    oor_nxt  = 1'b1;
    if (!nroot_r[rtdt_pkg::ST_RECIP]) begin
      if (big_r) begin
        temp_nxt = sign_r[rtdt_pkg::ST_RECIP] ? rtdt_pkg::T_LOW : rtdt_pkg::T_HIGH;
      end else if (sign_r[rtdt_pkg::ST_RECIP]) begin
        if (q_r > rtdt_pkg::Q_NEG_MAX) begin
          temp_nxt = rtdt_pkg::T_LOW;
        end else begin
          temp_nxt = -$signed(q_r);
          oor_nxt  = 1'b0;
        end
      end else begin
        if (q_r > rtdt_pkg::Q_POS_MAX) begin
          temp_nxt = rtdt_pkg::T_HIGH;
        end else begin
          temp_nxt = $signed(q_r);
          oor_nxt  = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[rtdt_pkg::ST_OUT]) begin
      temp_r <= temp_nxt;
      oor_r  <= oor_nxt;
    end
  end

  assign out_ch.valid        = ctl.valid[rtdt_pkg::ST_OUT];
  assign out_ch.resistance   = rq_r[rtdt_pkg::ST_OUT];
  assign out_ch.temperature  = temp_r;
  assign out_ch.out_of_range = oor_r;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for rtd_code_to_temperature_core. Drives converter
// words under several reference/nominal resistor settings, predicts the
// resistance, temperature and range flag of each word in integer
// arithmetic, and compares every result word in order. Both channels idle
// and stall at random; one long output stall fills the pipeline.
// ----------------------------------------------------------------------------
module tb_top;

  // Scaled Callendar-Van Dusen terms
  localparam longint unsigned ROOT_BIAS  = 64'd1758480889;  // A^2 - 4B, x1e14
  localparam longint unsigned FOUR_B_MAG = 64'd231000000;   // 4|B|, x1e14
  localparam longint          A_SCALED   = 64'd39083;       // A, x1e7
  localparam int              WATCHDOG   = 5000;

  typedef struct {
    logic [rtdt_pkg::RES_W-1:0]         resistance;
    logic signed [rtdt_pkg::TEMP_W-1:0] temperature;
    logic                               out_of_range;
  } reading_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rtdt_in_if  in_ch ();
  rtdt_out_if out_ch ();
  rtdt_cfg_if cfg_ch ();

  rtd_code_to_temperature_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  // Bench copy of the resistor registers
  logic [rtdt_pkg::REF_W-1:0] ref_ohms = rtdt_pkg::REFERENCE_OHMS_RST;
  logic [rtdt_pkg::NOM_W-1:0] nom_ohms = rtdt_pkg::NOMINAL_OHMS_RST;

  reading_t pending_readings[$];
  int       errors = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  int       hold_left = 0;
  int       quiet_cycles = 0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned one;
    root = 0;
    one = 64'd1 << 62;
    while (one > v) one = one >> 2;
    while (one != 0) begin
      if (v >= root + one) begin
        v = v - (root + one);
        root = (root >> 1) + one;
      end else begin
        root = root >> 1;
      end
      one = one >> 2;
    end
    return root;
  endfunction

  function automatic reading_t predict_reading(logic [rtdt_pkg::WORD_W-1:0] word);
    longint unsigned code, n, d, rq, p, q, r, tq, cq, s;
    longint          diff, num, den, v;
    reading_t        e;
    code = 64'(word[rtdt_pkg::WORD_W-1:1]);
    n = code * 64'(ref_ohms);
    d = 64'd32768 * 64'(nom_ohms);
    rq = ((n << rtdt_pkg::FRAC_BITS_DEFAULT) + (64'd1 << 14)) >> 15;
    if (rq > 64'(rtdt_pkg::R_MAX)) rq = 64'(rtdt_pkg::R_MAX);
    e.resistance = rq[rtdt_pkg::RES_W-1:0];
    e.temperature = rtdt_pkg::T_HIGH;
    e.out_of_range = 1'b1;
    // zero nominal or negative root argument keeps the high clamp
    if (d != 0) begin
      p = FOUR_B_MAG * n;
      q = p / d;
      r = p % d;
      if (q <= ROOT_BIAS) begin
        tq = (q << 32) + ((r << 32) / d);
        cq = ROOT_BIAS << 32;
        if (tq <= cq) begin
          s = int_sqrt(cq - tq);
          diff = (A_SCALED << 16) - longint'(s);
          num = diff * (64'sd20 << rtdt_pkg::FRAC_BITS_DEFAULT);
          den = 64'sd231 << 16;
          if (num >= 0) v = (num + den / 2) / den;
          else v = -((-num + den / 2) / den);
          e.out_of_range = 1'b0;
          if (v > 65535) begin
            v = 65535;
            e.out_of_range = 1'b1;
          end else if (v < -16384) begin
            v = -16384;
            e.out_of_range = 1'b1;
          end
          e.temperature = v[rtdt_pkg::TEMP_W-1:0];
        end
      end
    end
    return e;
  endfunction

  // Drive result ready: long hold first, then random idling
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check each result word against the oldest prediction
  always @(posedge clk) begin
    reading_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_readings.size() == 0) begin
        $error("unexpected result word: resistance %0d temperature %0d",
               out_ch.resistance, out_ch.temperature);
        errors++;
      end else begin
        e = pending_readings.pop_front();
        if (out_ch.resistance !== e.resistance) begin
          $error("resistance: expected %0d, got %0d", e.resistance, out_ch.resistance);
          errors++;
        end
        if (out_ch.temperature !== e.temperature) begin
          $error("temperature: expected %0d, got %0d", e.temperature, out_ch.temperature);
          errors++;
        end
        if (out_ch.out_of_range !== e.out_of_range) begin
          $error("out_of_range: expected %0d, got %0d", e.out_of_range,
                 out_ch.out_of_range);
          errors++;
        end
      end
    end
  end

  // Abort when no handshake happens for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG) begin
      $display("tb_top failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one word, idling first at random; valid stays high afterwards
  task automatic send_word(input logic [rtdt_pkg::WORD_W-1:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.rtd_word <= word;
    do @(posedge clk); while (!in_ch.ready);
    pending_readings.push_back(predict_reading(word));
  endtask

  // Drop valid and wait until the pipeline is empty
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rtdt_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rtdt_pkg::CFG_DATA_W-1:0] value);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == rtdt_pkg::REG_REFERENCE_OHMS) ref_ohms = value;
    else if (idx == rtdt_pkg::REG_NOMINAL_OHMS) nom_ohms = value[rtdt_pkg::NOM_W-1:0];
  endtask

  task automatic set_resistors(input int rref, input int rnom);
    write_reg(rtdt_pkg::REG_REFERENCE_OHMS, rtdt_pkg::CFG_DATA_W'(rref));
    write_reg(rtdt_pkg::REG_NOMINAL_OHMS, rtdt_pkg::CFG_DATA_W'(rnom));
  endtask

  // Mostly codes in the sensor's span, some anywhere
  function automatic logic [rtdt_pkg::WORD_W-1:0] random_word();
    if ($urandom_range(3) == 0) return rtdt_pkg::WORD_W'($urandom);
    return rtdt_pkg::WORD_W'($urandom_range(4000, 30000));
  endfunction

  // Field extremes, sensor span, negative root and clamps
  task automatic test_directed();
    logic [rtdt_pkg::WORD_W-1:0] words[] = '{16'h0000, 16'h0001, 16'h0002, 16'hFFFE,
                                             16'hFFFF, 16'h8000, 16'h5555, 16'hAAAA,
                                             16'd15240, 16'd15241, 16'd30000};
    foreach (words[i]) send_word(words[i]);
    // large ratio drives the root argument negative and the high clamp
    set_resistors(8191, 100);
    foreach (words[i]) send_word(words[i]);
    // zero nominal, then zero reference
    set_resistors(430, 0);
    send_word(16'h7777);
    set_resistors(0, 1023);
    send_word(16'hFFFF);
    // unknown indexes are ignored
    write_reg(2'd2, 13'h1FFF);
    write_reg(2'd3, 13'h0000);
    set_resistors(4300, 1000);
    send_word(16'hFFFF);
    send_word(16'h0000);
    drain();
  endtask

  task automatic test_random(input int count, input int s_pct, input int r_pct);
    int rref, rnom;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) begin
        case ($urandom_range(5))
          0: begin rref = 100;  rnom = 1000; end
          1: begin rref = 4300; rnom = 100;  end
          2: begin rref = 430;  rnom = 100;  end
          3: begin rref = $urandom_range(8191); rnom = $urandom_range(8191); end
          default: begin rref = $urandom_range(100, 4300); rnom = $urandom_range(100, 1000); end
        endcase
        if ($urandom_range(4) == 0) write_reg(rtdt_pkg::CFG_IDX_W'($urandom_range(2, 3)),
                                              rtdt_pkg::CFG_DATA_W'($urandom));
        set_resistors(rref, rnom);
      end
      send_word(random_word());
    end
    drain();
  endtask

  // Hold the result side while words keep coming, so the input stalls
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_resistors(430, 100);
    @(posedge clk);
    hold_left = 300;
    for (int i = 0; i < 80; i++) send_word(random_word());
    drain();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.rtd_word = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(400, 18, 85);
    test_random(400, 85, 18);
    test_backpressure();
    test_random(400, 0, 0);

    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
